// ===== rtl/core/mfbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfbc_pkg
// Shared types, widths and helpers of the streaming 2D median filter.
// ----------------------------------------------------------------------------
package mfbc_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_RADIUS = 2;

	localparam int PIX_W      = 8;
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 2;

	localparam int WIN_SIDE   = 2 * MAX_RADIUS + 1;
	localparam int WIN_N      = WIN_SIDE * WIN_SIDE;
	localparam int COL_DEPTH  = 2 * MAX_RADIUS;
	localparam int COL_AW     = $clog2(MAX_WIDTH);
	localparam int K_W        = $clog2(MAX_RADIUS + 1);
	localparam int RANK_W     = $clog2(WIN_N);
	localparam int CNT_W      = $clog2(MAX_WIDTH * ((1 << HEIGHT_W) + MAX_RADIUS) + MAX_RADIUS + 1);

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef logic [PIX_W-1:0] pix_t;
	// element index is column * WIN_SIDE + row, row 0 is the newest line
	typedef logic [WIN_N-1:0][PIX_W-1:0] win_t;
	typedef logic [WIN_SIDE-1:0][PIX_W-1:0] col_t;
	typedef logic [COL_DEPTH-1:0][PIX_W-1:0] entry_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FILTER_ENABLE = 2'd0,
		CFG_WINDOW_RADIUS = 2'd1,
		CFG_IMAGE_WIDTH   = 2'd2,
		CFG_IMAGE_HEIGHT  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic           has_out;
		logic           border;
		logic           last;
		logic [K_W-1:0] k;
	} item_ctl_t;

	// rank of the middle element among (2k+1)^2 values
	function automatic logic [RANK_W-1:0] med_rank(input logic [K_W-1:0] k);
		logic [RANK_W-1:0] kk;
		begin
			kk = RANK_W'(k);
			return RANK_W'(2 * kk * kk + 2 * kk);
		end
	endfunction

endpackage

// ===== rtl/core/median_filter_border_copy.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_border_copy
// Streaming 2D median filter on raster-order 8-bit pixels, borders copied.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one pixel or drain request per cycle while in_stall is low.
// After each frame the source sends k*width+k drain requests to flush it.
// Output channel (out_valid / out_stall): one pixel per request from request
// number k*width+k of the frame on; frame_end marks the last pixel.
// Configuration (cfg_valid / cfg_ready): always ready, write only while idle.
// Throughput: one request per cycle while in_stall is low. A result passes
// through column store read, window shift, compare, rank count and select
// into the queue before it shows on out_valid.
// A column store of one entry per image column keeps the last 2*MAX_RADIUS
// lines; each request reads its column and writes it back shifted, with a
// bypass when two requests in a row hit the same column.
// An eight-entry output queue with credit counting absorbs receiver stalls;
// in_stall rises only when all eight credits are held.
// Reset clears counters, queue and valid flags and loads the configuration defaults; the store needs no clearing.
// ----------------------------------------------------------------------------
module median_filter_border_copy
	import mfbc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PIX_W-1:0]      pixel_in,
	input  logic                  is_drain,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PIX_W-1:0]      pixel_out,
	output logic                  frame_end,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic                 enable_q;
	logic [K_W-1:0]       radius_q;
	logic [WIDTH_W-1:0]   width_q;
	logic [HEIGHT_W-1:0]  height_q;

	logic [K_W-1:0]       k_eff;
	logic [WIDTH_W-1:0]   w_eff;
	logic [HEIGHT_W-1:0]  h_eff;
	logic [CNT_W-1:0]     delay;

	logic [CNT_W-1:0]     in_cnt_q;
	logic [COL_AW-1:0]    in_col_q;
	logic [HEIGHT_W-1:0]  out_row_q;
	logic [COL_AW-1:0]    out_col_q;

	logic                 acc;
	logic                 has_out;
	logic                 out_last;
	logic                 interior;
	logic                 in_col_wrap;
	logic                 out_col_wrap;
	item_ctl_t            ctl_in;

	logic                 v_s1;
	item_ctl_t            ctl_s1;
	logic [COL_AW-1:0]    addr_s1;
	pix_t                 pix_s1;
	logic                 fwd_s1;
	entry_t               rd_s1;
	entry_t               last_wr_q;
	entry_t               entry;
	entry_t               wr_entry;
	col_t                 column;
	entry_t               col_mem [MAX_WIDTH];

	win_t                 win_q;
	logic                 v_s2;
	item_ctl_t            ctl_s2;

	logic                 done_valid;
	item_ctl_t            done_ctl;
	pix_t                 done_pixel;

	pix_t                 fifo_pix_q [FIFO_DEPTH];
	logic [FIFO_DEPTH-1:0] fifo_end_q;
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_AW:0]     fifo_cnt_q;
	logic [FIFO_AW:0]     cred_q;
	logic                 push;
	logic                 pop;
	logic                 release_nores;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			radius_q <= K_W'(2);
			width_q  <= WIDTH_W'(1024);
			height_q <= HEIGHT_W'(768);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FILTER_ENABLE: enable_q <= cfg_data[0];
				CFG_WINDOW_RADIUS: radius_q <= cfg_data[K_W-1:0];
				CFG_IMAGE_WIDTH:   width_q  <= cfg_data[WIDTH_W-1:0];
				CFG_IMAGE_HEIGHT:  height_q <= cfg_data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		k_eff = (int'(radius_q) > MAX_RADIUS) ? K_W'(MAX_RADIUS) : radius_q;
		if (width_q == '0) begin
			w_eff = WIDTH_W'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_eff = WIDTH_W'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		h_eff = (height_q == '0) ? HEIGHT_W'(1) : height_q;
		delay = CNT_W'(k_eff) * CNT_W'(w_eff) + CNT_W'(k_eff);
	end

	// position tracking
	assign acc = in_valid && !in_stall;

	always_comb begin
		has_out      = in_cnt_q >= delay;
		in_col_wrap  = WIDTH_W'(in_col_q) >= (w_eff - WIDTH_W'(1));
		out_col_wrap = WIDTH_W'(out_col_q) >= (w_eff - WIDTH_W'(1));
		out_last     = (out_row_q > (h_eff - HEIGHT_W'(1))) ||
			((out_row_q == (h_eff - HEIGHT_W'(1))) && out_col_wrap);
		interior     = enable_q &&
			(out_row_q >= HEIGHT_W'(k_eff)) &&
			(WIDTH_W'(out_col_q) >= WIDTH_W'(k_eff)) &&
			(((HEIGHT_W+1)'(out_row_q) + (HEIGHT_W+1)'(k_eff)) < (HEIGHT_W+1)'(h_eff)) &&
			((WIDTH_W'(out_col_q) + WIDTH_W'(k_eff)) < w_eff);
		ctl_in.has_out = has_out;
		ctl_in.border  = !interior;
		ctl_in.last    = has_out && out_last;
		ctl_in.k       = k_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (acc) begin
			if (has_out && out_last) begin
				in_cnt_q  <= '0;
				in_col_q  <= '0;
				out_row_q <= '0;
				out_col_q <= '0;
			end else begin
				in_cnt_q <= in_cnt_q + CNT_W'(1);
				in_col_q <= in_col_wrap ? '0 : in_col_q + COL_AW'(1);
				if (has_out) begin
					if (out_col_wrap) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + HEIGHT_W'(1);
					end else begin
						out_col_q <= out_col_q + COL_AW'(1);
					end
				end
			end
		end
	end

	// stage 1: column store read-modify-write and window shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ctl_s1  <= ctl_in;
			addr_s1 <= in_col_q;
			pix_s1  <= is_drain ? '0 : pixel_in;
			// the request now in stage 1 writes this column at the same edge
			fwd_s1  <= v_s1 && (addr_s1 == in_col_q);
			rd_s1   <= col_mem[in_col_q];
		end
		if (v_s1) begin
			col_mem[addr_s1] <= wr_entry;
			last_wr_q        <= wr_entry;
			win_q            <= {column, win_q[WIN_N-1:WIN_SIDE]};
		end
		ctl_s2 <= ctl_s1;
	end

	always_comb begin
		entry     = fwd_s1 ? last_wr_q : rd_s1;
		column[0] = pix_s1;
		for (int j = 1; j < WIN_SIDE; j++) begin
			column[j] = entry[j-1];
		end
		for (int j = 0; j < COL_DEPTH; j++) begin
			wr_entry[j] = column[j];
		end
	end

	mfbc_rank_select u_rank (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (v_s2),
		.in_ctl     (ctl_s2),
		.win        (win_q),
		.done_valid (done_valid),
		.done_ctl   (done_ctl),
		.done_pixel (done_pixel)
	);

	// output queue with credits
	assign push          = done_valid && done_ctl.has_out;
	assign release_nores = done_valid && !done_ctl.has_out;
	assign pop           = out_valid && !out_stall;
	assign in_stall      = cred_q == (FIFO_AW+1)'(FIFO_DEPTH);
	assign out_valid     = fifo_cnt_q != '0;
	assign pixel_out     = fifo_pix_q[rd_ptr_q];
	assign frame_end     = fifo_end_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_pix_q[wr_ptr_q] <= done_pixel;
			fifo_end_q[wr_ptr_q] <= done_ctl.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
			cred_q     <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			fifo_cnt_q <= fifo_cnt_q + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
			cred_q     <= cred_q + (FIFO_AW+1)'(acc) - (FIFO_AW+1)'(pop) -
				(FIFO_AW+1)'(release_nores);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> (fifo_cnt_q != (FIFO_AW+1)'(FIFO_DEPTH)))
		else $error("output queue overflow");

	a_credit_cover: assert property (@(posedge clk) disable iff (!arst_n)
		cred_q >= fifo_cnt_q)
		else $error("queued results exceed held credits");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && has_out && out_last) |=> (in_cnt_q == '0 && out_row_q == '0 &&
		out_col_q == '0))
		else $error("counters not cleared after last pixel");

	a_bypass_same_col: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && fwd_s1) |-> ($past(v_s1) && $past(addr_s1) == addr_s1))
		else $error("bypass taken for a different column");

endmodule

// ===== rtl/core/mfbc_rank_select.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfbc_rank_select
// Pipelined median of the window: pairwise compares, rank counts, select.
// ----------------------------------------------------------------------------
module mfbc_rank_select
	import mfbc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  item_ctl_t in_ctl,
	input  win_t      win,
	output logic      done_valid,
	output item_ctl_t done_ctl,
	output pix_t      done_pixel
);

	logic [WIN_N-1:0]            act;
	logic [WIN_N-1:0][WIN_N-1:0] lt;
	pix_t                        center;

	logic                        v_s3;
	item_ctl_t                   ctl_s3;
	logic [WIN_N-1:0][WIN_N-1:0] lt_s3;
	logic [WIN_N-1:0]            act_s3;
	win_t                        win_s3;
	pix_t                        center_s3;

	logic                        v_s4;
	item_ctl_t                   ctl_s4;
	logic [WIN_N-1:0][RANK_W-1:0] rank_s4;
	logic [WIN_N-1:0]            act_s4;
	win_t                        win_s4;
	pix_t                        center_s4;

	logic [RANK_W-1:0]           target;
	pix_t                        med;

	// active elements: the newest 2k+1 columns and rows
	always_comb begin
		for (int e = 0; e < WIN_N; e++) begin
			act[e] = ((e / WIN_SIDE) >= (WIN_SIDE - 1 - 2 * int'(in_ctl.k))) &&
				((e % WIN_SIDE) <= 2 * int'(in_ctl.k));
		end
		for (int i = 0; i < WIN_N; i++) begin
			for (int j = 0; j < WIN_N; j++) begin
				lt[i][j] = (i != j) && act[j] &&
					((win[j] < win[i]) || ((win[j] == win[i]) && (j < i)));
			end
		end
		center = win[0];
		for (int kk = 0; kk <= MAX_RADIUS; kk++) begin
			if (int'(in_ctl.k) == kk) begin
				center = win[(WIN_SIDE - 1 - kk) * WIN_SIDE + kk];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s3 <= in_valid;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s3    <= in_ctl;
		lt_s3     <= lt;
		act_s3    <= act;
		win_s3    <= win;
		center_s3 <= center;

		ctl_s4    <= ctl_s3;
		act_s4    <= act_s3;
		win_s4    <= win_s3;
		center_s4 <= center_s3;
		for (int i = 0; i < WIN_N; i++) begin
			rank_s4[i] <= RANK_W'($countones(lt_s3[i]));
		end
	end

	always_comb begin
		target = med_rank(ctl_s4.k);
		med    = '0;
		for (int i = 0; i < WIN_N; i++) begin
			med = med | (win_s4[i] & {PIX_W{act_s4[i] && (rank_s4[i] == target)}});
		end
	end

	assign done_valid = v_s4;
	assign done_ctl   = ctl_s4;
	assign done_pixel = ctl_s4.border ? center_s4 : med;

endmodule

// ===== tb/median_filter_border_copy_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_border_copy_tb
// Drives whole frames of random pixels plus their flush requests through the
// median filter. A local model of the line store predicts every output pixel
// and frame_end flag; outputs are checked in order. Both sides stall at random.
// ----------------------------------------------------------------------------
module median_filter_border_copy_tb;
	import mfbc_pkg::*;

	localparam int RING_LEN   = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
	localparam int SETTLE_CYC = 20;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct {
		logic [PIX_W-1:0] pix;
		logic             last;
	} pix_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [PIX_W-1:0]      pixel_in;
	logic                  is_drain;
	logic                  out_valid;
	logic                  out_stall;
	logic [PIX_W-1:0]      pixel_out;
	logic                  frame_end;
	logic                  cfg_valid;
	logic                  cfg_ready;
	cfg_idx_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	median_filter_border_copy DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .pixel_in(pixel_in), .is_drain(is_drain),
		.out_valid(out_valid), .out_stall(out_stall), .pixel_out(pixel_out),
		.frame_end(frame_end),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// shadow registers and line store
	logic             sh_enable;
	logic [1:0]       sh_radius;
	logic [WIDTH_W-1:0]  sh_width;
	logic [HEIGHT_W-1:0] sh_height;
	logic [PIX_W-1:0] line_ring [RING_LEN];
	int               pix_taken;
	int               pix_given;

	pix_result_t      pending_pix[$];
	int               errors;
	int               cycles;
	int               requests_sent;
	bit               in_idle_on;
	bit               out_idle_on;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("median_filter_border_copy_tb failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= out_idle_on && ($urandom_range(99) < 10);
	end

	function automatic int radius_eff();
		return (sh_radius > MAX_RADIUS) ? MAX_RADIUS : int'(sh_radius);
	endfunction

	function automatic int width_eff();
		if (sh_width < 1) return 1;
		if (sh_width > MAX_WIDTH) return MAX_WIDTH;
		return int'(sh_width);
	endfunction

	function automatic int height_eff();
		return (sh_height < 1) ? 1 : int'(sh_height);
	endfunction

	function automatic logic [PIX_W-1:0] window_median(int r, int c, int k, int w);
		logic [PIX_W-1:0] vals[WIN_N];
		logic [PIX_W-1:0] v;
		int n;
		int p;
		n = 0;
		for (int i = r - k; i <= r + k; i++) begin
			for (int j = c - k; j <= c + k; j++) begin
				v = line_ring[(i * w + j) % RING_LEN];
				p = n;
				while (p > 0 && vals[p-1] > v) begin
					vals[p] = vals[p-1];
					p--;
				end
				vals[p] = v;
				n++;
			end
		end
		return vals[(n - 1) / 2];
	endfunction

	// advance the store by one request, queue the output pixel if one is due
	function automatic void predict_pixel(logic [PIX_W-1:0] pix, logic drain);
		int k, w, h, total, delay, cur, o, r, c;
		pix_result_t res;
		k = radius_eff();
		w = width_eff();
		h = height_eff();
		total = w * h;
		delay = k * w + k;
		cur = pix_taken;
		if (!drain && cur < total) line_ring[cur % RING_LEN] = pix;
		pix_taken = cur + 1;
		if (cur < delay) return;
		o = pix_given;
		r = o / w;
		c = o % w;
		if (sh_enable && r >= k && c >= k && r + k < h && c + k < w)
			res.pix = window_median(r, c, k, w);
		else
			res.pix = line_ring[o % RING_LEN];
		res.last = (o + 1 >= total);
		if (res.last) begin
			pix_taken = 0;
			pix_given = 0;
		end else begin
			pix_given = o + 1;
		end
		pending_pix = {pending_pix, res};
	endfunction

	// output checker: a pixel is taken at the edge after this sample
	always @(negedge clk) begin
		pix_result_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pix.size() == 0) begin
				$display("%0t: unexpected pixel_out=%0d frame_end=%0b", $time, pixel_out,
					frame_end);
				errors++;
			end else begin
				exp_res = pending_pix.pop_front();
				if (pixel_out !== exp_res.pix) begin
					$display("%0t: pixel_out expected %0d actual %0d", $time, exp_res.pix,
						pixel_out);
					errors++;
				end
				if (frame_end !== exp_res.last) begin
					$display("%0t: frame_end expected %0b actual %0b", $time, exp_res.last,
						frame_end);
					errors++;
				end
			end
		end
	end

	task automatic send_pixel(logic [PIX_W-1:0] pix, logic drain);
		bit taken;
		in_valid <= 1'b1;
		pixel_in <= pix;
		is_drain <= drain;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		predict_pixel(pix, drain);
		requests_sent++;
		if (in_idle_on && $urandom_range(99) < 10) begin
			in_valid <= 1'b0;
			pixel_in <= PIX_W'($urandom);
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		bit taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		case (idx)
			CFG_FILTER_ENABLE: sh_enable = val[0];
			CFG_WINDOW_RADIUS: sh_radius = val[1:0];
			CFG_IMAGE_WIDTH:   sh_width = val[WIDTH_W-1:0];
			CFG_IMAGE_HEIGHT:  sh_height = val[HEIGHT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic setup(logic en, logic [CFG_DATA_W-1:0] rad, logic [CFG_DATA_W-1:0] w,
			logic [CFG_DATA_W-1:0] h);
		write_reg(CFG_FILTER_ENABLE, CFG_DATA_W'(en));
		write_reg(CFG_WINDOW_RADIUS, rad);
		write_reg(CFG_IMAGE_WIDTH, w);
		write_reg(CFG_IMAGE_HEIGHT, h);
		cfg_valid <= 1'b0;
	endtask

	// wait until every output pixel is out and the pipeline is quiet
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_pix.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// style 0: full range, 1: narrow range (many ties), 2: only 0 and 255
	task automatic send_frame(int style);
		int total, delay;
		logic [PIX_W-1:0] p;
		total = width_eff() * height_eff();
		delay = radius_eff() * width_eff() + radius_eff();
		for (int i = 0; i < total; i++) begin
			case (style)
				1: p = PIX_W'($urandom_range(100, 103));
				2: p = $urandom_range(1) ? 8'hff : 8'h00;
				default: p = PIX_W'($urandom);
			endcase
			send_pixel(p, 1'b0);
		end
		// some flush requests carry a pixel flag; they still count as flush
		for (int i = 0; i < delay; i++)
			send_pixel(PIX_W'($urandom), $urandom_range(99) >= 15);
	endtask

	task automatic test_small_frames();
		setup(1'b1, 1, 3, 3);
		send_frame(2);
		wait_idle();
		setup(1'b1, 0, 4, 2);
		send_frame(0);
		wait_idle();
		setup(1'b0, 2, 5, 5);
		send_frame(0);
		wait_idle();
		setup(1'b1, 2, 1, 1);
		send_frame(0);
		wait_idle();
	endtask

	task automatic test_saturation();
		// radius 3 acts as 2, width 0 as 1, height 0 as 1
		setup(1'b1, 3, 6, 5);
		send_frame(1);
		wait_idle();
		setup(1'b1, 1, 0, 0);
		send_frame(0);
		wait_idle();
	endtask

	task automatic test_large_sizes();
		out_idle_on = 1'b0;
		in_idle_on = 1'b0;
		// width 2047 acts as the maximum width
		setup(1'b1, 0, 2047, 1);
		send_frame(0);
		wait_idle();
		out_idle_on = 1'b1;
		in_idle_on = 1'b1;
		setup(1'b1, 1, 1, 100);
		send_frame(0);
		wait_idle();
	endtask

	task automatic test_random_frames();
		int start;
		int w, h;
		start = requests_sent;
		while (requests_sent - start < 250) begin
			w = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			h = $urandom_range(1, 10);
			in_idle_on = ($urandom_range(5) != 0);
			out_idle_on = in_idle_on;
			setup($urandom_range(3) != 0, CFG_DATA_W'($urandom_range(3)), CFG_DATA_W'(w),
				CFG_DATA_W'(h));
			repeat ($urandom_range(1, 2)) send_frame($urandom_range(2));
			wait_idle();
		end
		in_idle_on = 1'b1;
		out_idle_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		pixel_in = '0;
		is_drain = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_FILTER_ENABLE;
		cfg_data = '0;
		out_stall = 1'b0;
		errors = 0;
		cycles = 0;
		requests_sent = 0;
		in_idle_on = 1'b1;
		out_idle_on = 1'b1;
		sh_enable = 1'b0;
		sh_radius = 2'd2;
		sh_width = WIDTH_W'(1024);
		sh_height = HEIGHT_W'(768);
		pix_taken = 0;
		pix_given = 0;
		for (int i = 0; i < RING_LEN; i++) line_ring[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_small_frames();
		test_saturation();
		test_large_sizes();
		test_random_frames();

		wait_idle();
		if (errors == 0) begin
			$display("median_filter_border_copy_tb passed");
		end else begin
			$display("median_filter_border_copy_tb failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/mfbc_pkg.sv
rtl/core/mfbc_rank_select.sv
rtl/core/median_filter_border_copy.sv
tb/median_filter_border_copy_tb.sv
